// ----- rtl/core/packed_dna_reverse_complement_defines.svh -----
// assertion macros shared by the reverse complement rtl
// no dependencies; included by the modules that carry checks
`ifndef PACKED_DNA_REVERSE_COMPLEMENT_DEFINES_SVH
`define PACKED_DNA_REVERSE_COMPLEMENT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PDRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PDRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/pdrc_pkg.sv -----
// shared types, register codes and nucleotide complement functions
// no dependencies; imported by every reverse complement module
package pdrc_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_CODE_A = 2'd0;
   localparam logic [1:0] REG_CODE_C = 2'd1;
   localparam logic [1:0] REG_CODE_G = 2'd2;
   localparam logic [1:0] REG_CODE_T = 2'd3;

   localparam logic [1:0] CODE_A_RESET = 2'd0;
   localparam logic [1:0] CODE_C_RESET = 2'd1;
   localparam logic [1:0] CODE_G_RESET = 2'd3;
   localparam logic [1:0] CODE_T_RESET = 2'd2;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_READ,
      ST_SHAPE
   } state_type;

   typedef struct packed {
      logic a;
      logic c;
      logic g;
      logic t;
   } unused_type;

   typedef struct packed {
      logic [1:0] a;
      logic [1:0] c;
      logic [1:0] g;
      logic [1:0] t;
   } codes_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic last_load;
      logic last_emit;
      logic out_free;
   } status_type;

   // priority order follows the complement rule for non-permutation codes
   function automatic logic [1:0] comp_code(input logic [1:0] x, input codes_type cd);
      logic [1:0] r;
      if (x == cd.t) begin
         r = cd.a;
      end else if (x == cd.g) begin
         r = cd.c;
      end else if (x == cd.c) begin
         r = cd.g;
      end else if (x == cd.a) begin
         r = cd.t;
      end else begin
         r = x;
      end
      return r;
   endfunction

   // reverse the four groups and complement each
   function automatic logic [7:0] revcomp_byte(input logic [7:0] b, input codes_type cd);
      logic [7:0] r;
      r[7:6] = comp_code(b[1:0], cd);
      r[5:4] = comp_code(b[3:2], cd);
      r[3:2] = comp_code(b[5:4], cd);
      r[1:0] = comp_code(b[7:6], cd);
      return r;
   endfunction

endpackage

// ----- rtl/core/pdrc_csr.sv -----
// code registers behind the apb-style configuration port
// depends on pdrc_pkg
module pdrc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pdrc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [pdrc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [pdrc_pkg::CSR_DATA_W-1:0]    prdata,
   output pdrc_pkg::codes_type                codes
);
   import pdrc_pkg::*;

   codes_type  codes_ff;
   codes_type  codes_in;
   logic       wr_hit;
   logic [1:0] rd_val;

   assign wr_hit = psel && penable && pwrite;

   always_comb begin
      codes_in = codes_ff;
      if (wr_hit) begin
         case (paddr[3:2])
            REG_CODE_A: codes_in.a = pwdata[1:0];
            REG_CODE_C: codes_in.c = pwdata[1:0];
            REG_CODE_G: codes_in.g = pwdata[1:0];
            REG_CODE_T: codes_in.t = pwdata[1:0];
            default:    codes_in   = codes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff <= '{a: CODE_A_RESET, c: CODE_C_RESET, g: CODE_G_RESET, t: CODE_T_RESET};
      end else begin
         codes_ff <= codes_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_CODE_A: rd_val = codes_ff.a;
         REG_CODE_C: rd_val = codes_ff.c;
         REG_CODE_G: rd_val = codes_ff.g;
         REG_CODE_T: rd_val = codes_ff.t;
         default:    rd_val = 2'd0;
      endcase
   end

   assign prdata = {{(CSR_DATA_W-2){1'b0}}, rd_val};
   assign codes  = codes_ff;

endmodule

// ----- rtl/core/pdrc_ctrl.sv -----
// sequencer: loads bytes, then reads the store backwards one byte at a time
// depends on pdrc_pkg and the assertion macro header
`include "packed_dna_reverse_complement_defines.svh"
module pdrc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pdrc_pkg::status_type status,
   output pdrc_pkg::cmd_type    cmd
);
   import pdrc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && status.last_load) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SHAPE;
         end
         ST_SHAPE: begin
            if (status.out_free) begin
               state_in = status.last_emit ? ST_LOAD : ST_READ;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.wr_en    = 1'b0;
      cmd.rd_en    = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.wr_en = req_valid;
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
         end
         ST_SHAPE: begin
            cmd.load_out = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `PDRC_ASSERT_NOW(a_no_write_and_read, clock, reset, 1'b1, !(cmd.wr_en && cmd.rd_en), "store written and read together")
   `PDRC_ASSERT_NEXT(a_read_then_shape, clock, reset, cmd.rd_en, state_ff == ST_SHAPE, "read not followed by shaping")
   `PDRC_ASSERT_NEXT(a_hold_when_blocked, clock, reset, (state_ff == ST_SHAPE) && !status.out_free, state_ff == ST_SHAPE, "shaping left while output blocked")

endmodule

// ----- rtl/core/pdrc_dp.sv -----
// datapath: sequence store, counters, reverse complement and realignment, output register
// depends on pdrc_pkg and the assertion macro header
`include "packed_dna_reverse_complement_defines.svh"
module pdrc_dp #(
   parameter int MAX_BYTES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pdrc_pkg::cmd_type    cmd,
   output pdrc_pkg::status_type status,
   input  pdrc_pkg::codes_type  codes,
   input  logic [7:0]           req_packed_byte,
   input  logic [8:0]           req_nucl_count,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_byte
);
   import pdrc_pkg::*;

   localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int CW = $clog2(MAX_BYTES + 1);
   localparam int LEN_MAX = 4 * MAX_BYTES;
   localparam logic [12:0] LEN_MAX_V = 13'(LEN_MAX);

   logic [7:0]    mem [MAX_BYTES];
   logic [7:0]    rdata_ff;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [8:0]    len_ff, len_in;
   logic [7:0]    prev_ff, prev_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_out_byte_ff;
   logic          rsp_last_byte_ff;

   logic [8:0]    req_len;
   logic [8:0]    len_now;
   logic [9:0]    len_p3;
   logic [CW-1:0] nb_now;
   logic          first;
   logic [1:0]    pad;
   logic [2:0]    shift;
   logic [7:0]    cur;
   logic [15:0]   joined;

   // length clean-up: zero reads as one, overlong saturates
   always_comb begin
      req_len = (req_nucl_count == 9'd0) ? 9'd1 : req_nucl_count;
      if ({4'd0, req_len} > LEN_MAX_V) begin
         req_len = LEN_MAX_V[8:0];
      end
   end

   assign first   = (cnt_ff == '0);
   assign len_now = first ? req_len : len_ff;
   assign len_p3  = {1'b0, len_now} + 10'd3;
   assign nb_now  = CW'(len_p3[9:2]);

   assign status.last_load = (CW'(cnt_ff + CW'(1)) == nb_now);
   assign status.last_emit = (rd_ptr_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cnt_in    = cnt_ff;
      rd_ptr_in = rd_ptr_ff;
      len_in    = len_ff;
      prev_in   = prev_ff;
      if (cmd.wr_en) begin
         len_in = len_now;
         if (status.last_load) begin
            cnt_in    = '0;
            rd_ptr_in = CW'(nb_now - CW'(1));
            prev_in   = 8'd0;
         end else begin
            cnt_in = CW'(cnt_ff + CW'(1));
         end
      end
      if (cmd.load_out) begin
         prev_in = cur;
         if (!status.last_emit) begin
            rd_ptr_in = CW'(rd_ptr_ff - CW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         rd_ptr_ff <= '0;
         len_ff    <= 9'd0;
         prev_ff   <= 8'd0;
      end else begin
         cnt_ff    <= cnt_in;
         rd_ptr_ff <= rd_ptr_in;
         len_ff    <= len_in;
         prev_ff   <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cnt_ff[AW-1:0]] <= req_packed_byte;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_ptr_ff[AW-1:0]];
      end
   end

   // realign: drop twice the padding from the bottom, carry from the previous byte
   assign pad    = 2'(2'd0 - len_ff[1:0]);
   assign shift  = {pad, 1'b0};
   assign cur    = revcomp_byte(rdata_ff, codes);
   assign joined = {prev_ff, cur} >> shift;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_out_byte_ff  <= joined[7:0];
         rsp_last_byte_ff <= status.last_emit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_last_byte = rsp_last_byte_ff;

   `PDRC_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_ready, "pending result overwritten")
   `PDRC_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, {1'b0, cnt_ff} < (CW+1)'(MAX_BYTES), "load count beyond store depth")
   `PDRC_ASSERT_NEXT(a_last_flag, clock, reset, cmd.load_out && (rd_ptr_ff == '0), rsp_valid_ff && rsp_last_byte_ff, "final transfer not flagged")

endmodule

// ----- rtl/core/packed_dna_reverse_complement.sv -----
// reverse complement of a right-aligned 2-bit packed dna sequence
// loading accepts one byte per cycle; after the last byte the store is read backwards,
// one store read and one shaping step per result byte, shaping waits while the output
// is blocked, and no new byte is accepted until the last result byte is registered
// synchronous active-high reset empties the load count; code registers return to a=0 c=1 g=3 t=2
// depends on pdrc_pkg, pdrc_csr, pdrc_ctrl and pdrc_dp
module packed_dna_reverse_complement #(
   parameter int MAX_BYTES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_packed_byte,
   input  logic [8:0]                      req_nucl_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_last_byte,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pdrc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pdrc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pdrc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import pdrc_pkg::*;

   codes_type  codes;
   cmd_type    cmd;
   status_type status;

   assign pready = 1'b1;

   pdrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .codes   (codes)
   );

   pdrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pdrc_dp #(
      .MAX_BYTES (MAX_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .codes           (codes),
      .req_packed_byte (req_packed_byte),
      .req_nucl_count  (req_nucl_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule

// ----- dv/packed_dna_reverse_complement_tb.sv -----
// self-checking testbench for packed_dna_reverse_complement: random and directed
// sequences, varied nucleotide codes over the csr port, scoreboarded output bytes
// depends on pdrc_pkg and the packed_dna_reverse_complement rtl
`timescale 1ns / 100ps

module packed_dna_reverse_complement_tb;
   import pdrc_pkg::*;

   localparam int MAX_BYTES      = 64;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int IDLE_PERCENT   = 23;
   localparam int PHASES         = 7;
   localparam int PHASE_ITEMS    = 8;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic [8:0] nucl_count;
   } load_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rc_byte_type;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_packed_byte = '0;
   logic [8:0]            req_nucl_count  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_last_byte;
   logic                  psel            = 1'b0;
   logic                  penable         = 1'b0;
   logic                  pwrite          = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr           = '0;
   logic [CSR_DATA_W-1:0] pwdata          = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // stimulus and scoreboard
   load_item_type pending_loads[$];
   rc_byte_type   expected_rc[$];
   load_item_type next_load;
   rc_byte_type   seen_rc;
   logic       req_done      = 1'b0;
   logic       steady        = 1'b0;
   int         hold_requests = 0;
   int         hold_seen     = 0;
   int         hold_left     = 0;
   int         mismatches    = 0;
   int         idle_cycles   = 0;

   // predictor state
   logic [7:0] seq_store[MAX_BYTES];
   int         store_fill = 0;
   int         held_len   = 0;
   codes_type  code_set   = '{a: CODE_A_RESET, c: CODE_C_RESET, g: CODE_G_RESET,
                              t: CODE_T_RESET};

   packed_dna_reverse_complement #(
      .MAX_BYTES(MAX_BYTES)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_packed_byte(req_packed_byte),
      .req_nucl_count (req_nucl_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int clamp_length(input logic [8:0] cnt);
      int n;
      n = cnt;
      if (n == 0) n = 1;
      if (n > 4 * MAX_BYTES) n = 4 * MAX_BYTES;
      return n;
   endfunction

   function automatic logic [1:0] complement_nt(input logic [1:0] x);
      logic [1:0] r;
      if (x == code_set.t) r = code_set.a;
      else if (x == code_set.g) r = code_set.c;
      else if (x == code_set.c) r = code_set.g;
      else if (x == code_set.a) r = code_set.t;
      else r = x;
      return r;
   endfunction

   // last group of the input becomes the first of the output
   function automatic logic [7:0] revcomp_packed(input logic [7:0] b);
      logic [7:0] r;
      r = '0;
      for (int j = 0; j < 4; j++) begin
         r = {r[5:0], complement_nt(b[2*j +: 2])};
      end
      return r;
   endfunction

   task automatic predict_revcomp_load(input logic [7:0] pb, input logic [8:0] cnt);
      int          nbytes;
      int          shift;
      logic [7:0]  cur;
      logic [7:0]  prev;
      logic [15:0] wide;
      rc_byte_type rc;
      if (store_fill == 0) held_len = clamp_length(cnt);
      nbytes = (held_len + 3) / 4;
      seq_store[store_fill] = pb;
      store_fill++;
      if (store_fill < nbytes) return;
      // right-align again: drop the padding that now sits at the low end
      shift = 2 * ((4 - (held_len % 4)) % 4);
      prev  = '0;
      for (int k = 0; k < nbytes; k++) begin
         cur  = revcomp_packed(seq_store[nbytes - 1 - k]);
         wide = ({8'h00, cur} >> shift) | ({8'h00, prev} << (8 - shift));
         rc.out_byte  = wide[7:0];
         rc.last_byte = (k + 1 == nbytes);
         expected_rc.push_back(rc);
         prev = cur;
      end
      store_fill = 0;
   endtask

   task automatic flag_mismatch(input string what, input logic [31:0] expv,
                                input logic [31:0] actv);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s: expected %0h, got %0h at %0t", what, expv, actv, $realtime);
   endtask

   // driver: one payload held until its transfer completes
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_done) begin
         if (pending_loads.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
            next_load = pending_loads.pop_front();
            req_valid       <= 1'b1;
            req_packed_byte <= next_load.packed_byte;
            req_nucl_count  <= next_load.nucl_count;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || $urandom_range(99) >= IDLE_PERCENT;
      end
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin
      req_done = !reset && req_valid && req_ready;
      if (req_done) predict_revcomp_load(req_packed_byte, req_nucl_count);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rc.size() == 0) begin
            flag_mismatch("unexpected output transfer", 'x, 32'({rsp_last_byte, rsp_out_byte}));
         end else begin
            seen_rc = expected_rc.pop_front();
            if (rsp_out_byte !== seen_rc.out_byte)
               flag_mismatch("out_byte", 32'(seen_rc.out_byte), 32'(rsp_out_byte));
            if (rsp_last_byte !== seen_rc.last_byte)
               flag_mismatch("last_byte", 32'(seen_rc.last_byte), 32'(rsp_last_byte));
         end
      end
      if (reset || req_done || (rsp_valid && rsp_ready) || psel) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL packed_dna_reverse_complement");
         $finish;
      end
   end

   task automatic csr_access(input logic [1:0] idx, input logic wr, input logic [1:0] val);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = wr;
      paddr   = {idx, 2'b00};
      pwdata  = {30'd0, val};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (!wr && prdata[1:0] !== val) flag_mismatch("csr read back", 32'(val), prdata);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_codes(input logic [1:0] a, input logic [1:0] c, input logic [1:0] g,
                            input logic [1:0] t);
      csr_access(REG_CODE_A, 1'b1, a);
      csr_access(REG_CODE_C, 1'b1, c);
      csr_access(REG_CODE_G, 1'b1, g);
      csr_access(REG_CODE_T, 1'b1, t);
      code_set = '{a: a, c: c, g: g, t: t};
      csr_access(REG_CODE_A, 1'b0, a);
      csr_access(REG_CODE_C, 1'b0, c);
      csr_access(REG_CODE_G, 1'b0, g);
      csr_access(REG_CODE_T, 1'b0, t);
      @(posedge clock);
   endtask

   // count travels with the first byte; later count fields are don't-care noise
   task automatic queue_sequence(input logic [8:0] cnt, input bit fixed, input logic [7:0] fill,
                                 output int nbytes);
      load_item_type it;
      nbytes = (clamp_length(cnt) + 3) / 4;
      for (int i = 0; i < nbytes; i++) begin
         it.packed_byte = fixed ? fill : 8'($urandom);
         it.nucl_count  = (i == 0) ? cnt : 9'($urandom);
         pending_loads.push_back(it);
      end
   endtask

   task automatic wait_for_idle();
      while (pending_loads.size() != 0 || req_valid || expected_rc.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int perm[4];
      int j;
      int tmp;
      int n;
      int queued;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // directed: reset codes, short lengths over every padding amount, zero length
      queue_sequence(9'd1, 1'b1, 8'hff, n);
      queue_sequence(9'd0, 1'b1, 8'h00, n);
      queue_sequence(9'd2, 1'b1, 8'hff, n);
      queue_sequence(9'd3, 1'b1, 8'h1b, n);
      queue_sequence(9'd4, 1'b1, 8'he4, n);
      queue_sequence(9'd5, 1'b1, 8'h55, n);
      queue_sequence(9'd6, 1'b1, 8'haa, n);
      queue_sequence(9'd7, 1'b0, 8'h00, n);
      queue_sequence(9'd8, 1'b0, 8'h00, n);
      queue_sequence(9'd9, 1'b0, 8'h00, n);
      wait_for_idle();

      for (int ph = 0; ph < PHASES; ph++) begin
         perm = '{0, 1, 2, 3};
         for (int i = 3; i > 0; i--) begin
            j       = $urandom_range(i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
         end
         case (ph)
            0: set_codes(2'd3, 2'd2, 2'd1, 2'd0);
            2: set_codes(2'd0, 2'd0, 2'd0, 2'd0);
            3: set_codes(2'd3, 2'd3, 2'd3, 2'd3);
            4: set_codes(2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
            6: set_codes(CODE_A_RESET, CODE_C_RESET, CODE_G_RESET, CODE_T_RESET);
            default: set_codes(2'(perm[0]), 2'(perm[1]), 2'(perm[2]), 2'(perm[3]));
         endcase
         steady = (ph == 3);
         queued = 0;
         if (ph == 3) begin
            // overlong count saturates to a full store
            queue_sequence(9'($urandom_range(257, 511)), 1'b0, 8'h00, n);
            queued += n;
         end
         if (ph == 2) begin
            // fill the block while the output side is held off
            for (int s = 0; s < 2; s++) begin
               queue_sequence(9'($urandom_range(24, 40)), 1'b0, 8'h00, n);
               queued += n;
            end
            hold_requests++;
         end
         while (queued < PHASE_ITEMS) begin
            queue_sequence(9'($urandom_range(0, 48)), 1'b0, 8'h00, n);
            queued += n;
         end
         wait_for_idle();
         steady = 1'b0;
      end

      if (mismatches == 0 && expected_rc.size() == 0) begin
         $display("PASS packed_dna_reverse_complement");
      end else begin
         $display("FAIL packed_dna_reverse_complement");
      end
      $finish;
   end

endmodule
